>>> sv/hdri_pkg.sv
// shared types, constants and the arctangent table for the heading integrator
// no dependencies
package hdri_pkg;

  localparam int unsigned TABLE_SIZE = 24;
  localparam int unsigned ANGLE_W    = 18;

  localparam logic [23:0] GAIN_Q24 = 24'd10188014;

  localparam logic signed [ANGLE_W-1:0] FULL_TURN    = 18'sd23040;
  localparam logic signed [ANGLE_W-1:0] HALF_TURN    = 18'sd11520;
  localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 18'sd5760;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_INIT,
    ST_ROTATE,
    ST_ACCUM
  } hdri_state_e;

  typedef struct packed {
    logic capture;
    logic mul_lo;
    logic mul_hi;
    logic init;
    logic rotate;
    logic commit;
  } hdri_cmd_t;

  typedef struct packed {
    logic moving;
    logic last_step;
  } hdri_status_t;

  // atan(2^-i) in units of 2^-22 degree
  function automatic logic [27:0] atan_entry(input logic [4:0] idx);
    logic [27:0] v;
    case (idx)
      5'd0:    v = 28'd188743680;
      5'd1:    v = 28'd111421900;
      5'd2:    v = 28'd58872272;
      5'd3:    v = 28'd29884485;
      5'd4:    v = 28'd15000234;
      5'd5:    v = 28'd7507429;
      5'd6:    v = 28'd3754631;
      5'd7:    v = 28'd1877430;
      5'd8:    v = 28'd938729;
      5'd9:    v = 28'd469366;
      5'd10:   v = 28'd234683;
      5'd11:   v = 28'd117342;
      5'd12:   v = 28'd58671;
      5'd13:   v = 28'd29335;
      5'd14:   v = 28'd14668;
      5'd15:   v = 28'd7334;
      5'd16:   v = 28'd3667;
      5'd17:   v = 28'd1833;
      5'd18:   v = 28'd917;
      5'd19:   v = 28'd458;
      5'd20:   v = 28'd229;
      5'd21:   v = 28'd115;
      5'd22:   v = 28'd57;
      5'd23:   v = 28'd29;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

endpackage

>>> sv/hdri_datapath.sv
// datapath: speed register, distance multiply, shared cordic stage and
// saturating position accumulators; uses hdri_pkg
module hdri_datapath #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic signed [15:0]              heading_i,
  input  logic [19:0]                     elapsed_time_i,
  input  logic                            moving_i,
  input  hdri_pkg::hdri_cmd_t             cmd_i,
  output hdri_pkg::hdri_status_t          status_o,
  output logic signed [POSITION_BITS-1:0] position_x_o,
  output logic signed [POSITION_BITS-1:0] position_y_o
);

  localparam int unsigned XW = 48;
  localparam int unsigned DW = XW - 8;
  localparam int unsigned ZW = 32;
  localparam int unsigned SW = ((POSITION_BITS > DW) ? POSITION_BITS : DW) + 1;
  localparam int unsigned CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int unsigned AW = hdri_pkg::ANGLE_W;

  localparam logic signed [SW-1:0] POS_HI =
    {{(SW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] POS_LO =
    {{(SW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

  logic [15:0]                     speed_q;
  logic [35:0]                     dist_q, dist_d;
  logic [59:0]                     prod_q, prod_d;
  logic signed [13:0]              angle_q;
  logic                            flip_q, moving_q;
  logic signed [XW-1:0]            x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]            z_q, z_d;
  logic [CW-1:0]                   step_q, step_d;
  logic signed [POSITION_BITS-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  logic signed [AW-1:0] a0, a1, a2;
  logic                 flip_d;
  logic [17:0]          mul_a;
  logic [41:0]          mul_p;
  logic [43:0]          x0_mag;
  logic signed [XW-1:0] x0, dx, dy;
  logic signed [ZW-1:0] atan_v;
  logic signed [XW-1:0] rx, ry;
  logic signed [DW-1:0] del_x, del_y;

  function automatic logic signed [POSITION_BITS-1:0] sat_add(
    input logic signed [POSITION_BITS-1:0] acc,
    input logic signed [DW-1:0]            del
  );
    logic signed [SW-1:0] sum;
    logic signed [POSITION_BITS-1:0] r;
    sum = {{(SW-POSITION_BITS){acc[POSITION_BITS-1]}}, acc}
        + {{(SW-DW){del[DW-1]}}, del};
    if (sum > POS_HI) begin
      r = POS_HI[POSITION_BITS-1:0];
    end else if (sum < POS_LO) begin
      r = POS_LO[POSITION_BITS-1:0];
    end else begin
      r = sum[POSITION_BITS-1:0];
    end
    return r;
  endfunction

  // angle reduction into plus or minus a half turn and fold into plus or minus a quarter
  always_comb begin
    a0 = {AW{1'b0}} - {{(AW-16){heading_i[15]}}, heading_i};
    if (a0 >= hdri_pkg::HALF_TURN) begin
      a1 = a0 - hdri_pkg::FULL_TURN;
    end else if (a0 < -hdri_pkg::HALF_TURN) begin
      a1 = a0 + hdri_pkg::FULL_TURN;
    end else begin
      a1 = a0;
    end
    flip_d = 1'b0;
    a2     = a1;
    if (a1 > hdri_pkg::QUARTER_TURN) begin
      a2     = a1 - hdri_pkg::HALF_TURN;
      flip_d = 1'b1;
    end else if (a1 < -hdri_pkg::QUARTER_TURN) begin
      a2     = a1 + hdri_pkg::HALF_TURN;
      flip_d = 1'b1;
    end
  end

  assign dist_d = {20'd0, speed_q} * {16'd0, elapsed_time_i};
  assign mul_a  = cmd_i.mul_hi ? dist_q[35:18] : dist_q[17:0];
  assign mul_p  = {24'd0, mul_a} * {18'd0, hdri_pkg::GAIN_Q24};

  always_comb begin
    prod_d = prod_q;
    if (cmd_i.mul_lo) begin
      prod_d = {18'd0, mul_p};
    end else if (cmd_i.mul_hi) begin
      prod_d = prod_q + {mul_p, 18'd0};
    end
  end

  assign x0_mag = prod_q[59:16];
  assign x0     = flip_q ? -$signed({4'd0, x0_mag}) : $signed({4'd0, x0_mag});
  assign dx     = y_q >>> step_q;
  assign dy     = x_q >>> step_q;
  assign atan_v = $signed({4'd0, hdri_pkg::atan_entry(5'(step_q))});

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    step_d = step_q;
    if (cmd_i.init) begin
      x_d    = x0;
      y_d    = '0;
      z_d    = {{(ZW-30){angle_q[13]}}, angle_q, 16'd0};
      step_d = '0;
    end else if (cmd_i.rotate) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_v;
      end
      step_d = step_q + CW'(1);
    end
  end

  // round to whole nanometres
  assign rx    = (x_q + XW'(128)) >>> 8;
  assign ry    = (y_q + XW'(128)) >>> 8;
  assign del_x = moving_q ? rx[DW-1:0] : '0;
  assign del_y = moving_q ? ry[DW-1:0] : '0;

  assign acc_x_d = sat_add(acc_x_q, del_x);
  assign acc_y_d = sat_add(acc_y_q, del_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= 16'd1000;
      acc_x_q <= '0;
      acc_y_q <= '0;
    end else begin
      if (cfg_we_i) begin
        speed_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        acc_x_q <= acc_x_d;
        acc_y_q <= acc_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dist_q   <= dist_d;
      angle_q  <= a2[13:0];
      flip_q   <= flip_d;
      moving_q <= moving_i;
    end
    prod_q <= prod_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    step_q <= step_d;
  end

  assign status_o.moving    = moving_q;
  assign status_o.last_step = (step_q == CW'(CORDIC_STEPS - 1));
  assign position_x_o       = acc_x_q;
  assign position_y_o       = acc_y_q;

endmodule

>>> sv/hdri_ctrl.sv
// controller state machine sequencing multiply, cordic and accumulate
// uses hdri_pkg
module hdri_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  hdri_pkg::hdri_status_t status_i,
  output hdri_pkg::hdri_cmd_t    cmd_o
);

  hdri_pkg::hdri_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hdri_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = hdri_pkg::ST_MUL_LO;
      end
      hdri_pkg::ST_MUL_LO: begin
        state_d = status_i.moving ? hdri_pkg::ST_MUL_HI : hdri_pkg::ST_ACCUM;
      end
      hdri_pkg::ST_MUL_HI: state_d = hdri_pkg::ST_INIT;
      hdri_pkg::ST_INIT:   state_d = hdri_pkg::ST_ROTATE;
      hdri_pkg::ST_ROTATE: begin
        if (status_i.last_step) state_d = hdri_pkg::ST_ACCUM;
      end
      hdri_pkg::ST_ACCUM: begin
        if (out_free) state_d = hdri_pkg::ST_IDLE;
      end
      default: state_d = hdri_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      hdri_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      hdri_pkg::ST_MUL_LO: cmd_o.mul_lo = 1'b1;
      hdri_pkg::ST_MUL_HI: cmd_o.mul_hi = 1'b1;
      hdri_pkg::ST_INIT:   cmd_o.init   = 1'b1;
      hdri_pkg::ST_ROTATE: cmd_o.rotate = 1'b1;
      hdri_pkg::ST_ACCUM:  cmd_o.commit = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hdri_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input transfer taken while an item is in flight");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("result not presented after accumulate");

  a_rotate_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hdri_pkg::ST_ROTATE && status_i.last_step) |=>
    (state_q == hdri_pkg::ST_ACCUM))
    else $error("cordic did not hand over to accumulate");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.commit)
    else $error("pending result overwritten");
`endif

endmodule

>>> sv/heading_dead_reckoning_integrator.sv
// Heading dead-reckoning integrator. Each input transfer carries a heading, an
// elapsed time and a moving flag; the block returns one position per transfer.
// When moving, the distance speed_estimate * elapsed_time is rotated by minus
// the heading through a CORDIC that does one rotation per cycle in a single
// shared stage, and added to saturating X/Y accumulators in nanometres. A moving
// item goes through capture, a low and a high half-width multiply, start vector
// load, CORDIC_STEPS rotations and the accumulate before the next input transfer;
// an item with moving clear goes through capture, the low multiply and the
// accumulate. A finished result waits in the output register while the
// next item is accepted and worked on; that item's accumulate then waits until
// the held result has been taken. speed_estimate resets to 1000 mm/s and
// should be written only while no item is in flight.
module heading_dead_reckoning_integrator #(
  parameter int unsigned CORDIC_STEPS  = 16,
  parameter int unsigned POSITION_BITS = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [15:0]                     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              heading_i,
  input  logic [19:0]                     elapsed_time_i,
  input  logic                            moving_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [POSITION_BITS-1:0] position_x_o,
  output logic signed [POSITION_BITS-1:0] position_y_o
);

  hdri_pkg::hdri_cmd_t    cmd;
  hdri_pkg::hdri_status_t status;

  hdri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hdri_datapath #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .heading_i      (heading_i),
    .elapsed_time_i (elapsed_time_i),
    .moving_i       (moving_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .position_x_o   (position_x_o),
    .position_y_o   (position_y_o)
  );

endmodule

>>> bench/heading_dead_reckoning_integrator_tb.sv
// self-checking bench for heading_dead_reckoning_integrator: drives heading samples
// with random idling, predicts each position in fixed point and checks every transfer
// depends on hdri_pkg and the rtl sources in sv
module heading_dead_reckoning_integrator_tb;

  localparam int unsigned POS_W        = 48;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          DRAIN_CYCLES   = 30;

  localparam longint HALF_TURN_DEG64    = 11520;
  localparam longint QUARTER_TURN_DEG64 = 5760;
  localparam longint FULL_TURN_DEG64    = 23040;
  localparam longint ROT_GAIN_Q24       = 10188014;
  localparam longint ATAN_LUT [0:15] = '{
    188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
    3754631, 1877430, 938729, 469366, 234683, 117342,
    58671, 29335, 14668, 7334
  };

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } position_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [15:0]             cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [15:0]      heading_i;
  logic [19:0]             elapsed_time_i;
  logic                    moving_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [POS_W-1:0] position_x_o;
  logic signed [POS_W-1:0] position_y_o;

  position_t   expected_positions[$];
  logic [15:0] speed_mm_s = 16'd1000;
  longint      track_x = 0;
  longint      track_y = 0;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_len       = 0;
  int          hold_tag       = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  int          idle_cycles    = 0;
  int unsigned fail_count     = 0;
  int unsigned samples_sent   = 0;
  int unsigned moving_sent    = 0;
  int unsigned positions_seen = 0;
  int unsigned speed_writes   = 0;

  heading_dead_reckoning_integrator #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .POSITION_BITS (POS_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .heading_i      (heading_i),
    .elapsed_time_i (elapsed_time_i),
    .moving_i       (moving_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .position_x_o   (position_x_o),
    .position_y_o   (position_y_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint sat_add(input longint acc, input longint delta);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (POS_W - 1)) - 1;
    lo = -hi - 1;
    if (delta > 0 && acc > hi - delta) return hi;
    if (delta < 0 && acc < lo - delta) return lo;
    return acc + delta;
  endfunction

  function automatic void advance_position(input logic signed [15:0] hdg,
                                           input logic [19:0] span, input logic mv);
    longint    ang;
    longint    travel;
    longint    vx;
    longint    vy;
    longint    vz;
    longint    dx;
    longint    dy;
    position_t p;
    if (mv) begin
      ang = -longint'(hdg);
      while (ang >= HALF_TURN_DEG64) ang -= FULL_TURN_DEG64;
      while (ang < -HALF_TURN_DEG64) ang += FULL_TURN_DEG64;
      travel = longint'(speed_mm_s) * longint'(span);
      vx = (travel * ROT_GAIN_Q24) >>> 16;
      if (ang > QUARTER_TURN_DEG64) begin
        ang -= HALF_TURN_DEG64;
        vx = -vx;
      end else if (ang < -QUARTER_TURN_DEG64) begin
        ang += HALF_TURN_DEG64;
        vx = -vx;
      end
      vy = 0;
      vz = ang * 65536;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vz >= 0) begin
          vx -= dx;
          vy += dy;
          vz -= ATAN_LUT[i];
        end else begin
          vx += dx;
          vy -= dy;
          vz += ATAN_LUT[i];
        end
      end
      track_x = sat_add(track_x, (vx + 128) >>> 8);
      track_y = sat_add(track_y, (vy + 128) >>> 8);
    end
    p.x = track_x[POS_W-1:0];
    p.y = track_y[POS_W-1:0];
    expected_positions.push_back(p);
  endfunction

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checking and watchdog
  always @(posedge clk_i) begin
    position_t exp_pos;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        positions_seen++;
        if (expected_positions.size() == 0) begin
          $error("position transfer with nothing expected: x %0d y %0d",
                 position_x_o, position_y_o);
          fail_count++;
        end else begin
          exp_pos = expected_positions.pop_front();
          if (position_x_o !== exp_pos.x) begin
            $error("position_x expected %0d, got %0d", exp_pos.x, position_x_o);
            fail_count++;
          end
          if (position_y_o !== exp_pos.y) begin
            $error("position_y expected %0d, got %0d", exp_pos.y, position_y_o);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] hdg, input logic [19:0] span,
                             input logic mv);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    heading_i      <= hdg;
    elapsed_time_i <= span;
    moving_i       <= mv;
    do @(posedge clk_i); while (!in_ready_o);
    advance_position(hdg, span, mv);
    samples_sent++;
    if (mv) moving_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_positions.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_speed(input logic [15:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    speed_mm_s = value;
    speed_writes++;
  endtask

  task automatic test_directed();
    send_idle_pct  = 24;
    recv_stall_pct = 62;
    send_sample(16'sd0, 20'd1000, 1'b0);
    send_sample(16'sd0, 20'hFFFFF, 1'b1);
    send_sample(16'sd23040, 20'd500000, 1'b1);
    send_sample(-16'sd23040, 20'd500000, 1'b1);
    send_sample(16'sd32767, 20'd123456, 1'b1);
    send_sample(16'sh8000, 20'd654321, 1'b1);
    send_sample(16'sd5760, 20'hFFFFF, 1'b1);
    send_sample(-16'sd5760, 20'hFFFFF, 1'b1);
    send_sample(16'sd5761, 20'hFFFFF, 1'b1);
    send_sample(-16'sd5761, 20'hFFFFF, 1'b1);
    send_sample(16'sd11520, 20'hFFFFF, 1'b1);
    send_sample(-16'sd11520, 20'hFFFFF, 1'b1);
    send_sample(16'sd1, 20'd777, 1'b1);
    send_sample(-16'sd1, 20'd777, 1'b1);
    send_sample(16'sd0, 20'd0, 1'b1);
    send_sample(16'sh5555, 20'hAAAAA, 1'b0);
    set_speed(16'd0);
    send_sample(16'sd1234, 20'hFFFFF, 1'b1);
    send_sample(-16'sh5556, 20'h55555, 1'b1);
    set_speed(16'hFFFF);
    send_sample(-16'sd2880, 20'hFFFFF, 1'b1);
    send_sample(16'sd11519, 20'hFFFFF, 1'b1);
    send_sample(-16'sd11519, 20'hFFFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 300;
    hold_tag++;
    repeat (8) send_sample(16'(int'($urandom_range(46080)) - 23040), 20'($urandom), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_phase(input int n, input int sidle, input int rstall,
                                   input logic [15:0] spd);
    logic signed [15:0] hdg;
    logic [19:0]        span;
    logic               mv;
    set_speed(spd);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    repeat (n) begin
      case ($urandom_range(9))
        0:       hdg = 16'($urandom);
        1:       hdg = 16'(int'($urandom_range(16)) * 2880 - 23040
                           + int'($urandom_range(2)) - 1);
        default: hdg = 16'(int'($urandom_range(46080)) - 23040);
      endcase
      case ($urandom_range(7))
        0:       span = 20'd0;
        1:       span = 20'hFFFFF;
        2:       span = 20'($urandom);
        default: span = 20'($urandom_range(20000));
      endcase
      mv = ($urandom_range(7) != 0);
      send_sample(hdg, span, mv);
    end
    wait_drained();
  endtask

  // long straight legs at full speed, out along one heading and back along another
  task automatic test_long_travel();
    set_speed(16'hFFFF);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (32) send_sample(16'sd2880, 20'hFFFFF, ($urandom_range(31) != 0));
    repeat (32) send_sample(-16'sd8640, 20'hFFFFF, ($urandom_range(31) != 0));
    wait_drained();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    heading_i      = '0;
    elapsed_time_i = '0;
    moving_i       = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random_phase(110, 24, 62, 16'($urandom));
    test_random_phase(110, 62, 24, 16'd1);
    test_random_phase(110, 0, 0, 16'hFFFF);
    test_long_travel();

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (expected_positions.size() != 0) begin
      $error("%0d positions never arrived", expected_positions.size());
    end
    $display("%0d samples sent (%0d moving), %0d positions checked, %0d speed writes",
             samples_sent, moving_sent, positions_seen, speed_writes);
    $display("angle wrap and quadrant folds, a long receiver hold-off, three idling mixes");
    $display("and long full-speed legs out and back were run");
    if (fail_count == 0 && expected_positions.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
